/* src/cfa_pkg.sv */
`default_nettype none
package cfa_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int MARK_W     = 11;
  localparam int CNT_W      = (IDX_W + 1 > MARK_W) ? IDX_W + 1 : MARK_W;

  localparam logic [31:0] KSEG_OFFSET = 32'h8000_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_FRAME_BASE  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_MEM    = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ASCAN = 7'b0000100,
    ST_AMARK = 7'b0001000,
    ST_FSRCH = 7'b0010000,
    ST_FREAD = 7'b0100000,
    ST_FCLR  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

/* src/cfa_ram.sv */
`default_nettype none
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/contiguous_frame_allocator.sv */
`default_nettype none
// Channel | Ports                                      | Handshake
// ------- | ------------------------------------------ | ---------------------------------
// input   | in_op, in_page_count, in_address           | taken when start && !busy
// result  | out_start_address, out_status              | out_valid strobe, one cycle
// config  | cfg_index, cfg_wdata                       | written when cfg_we is high
//
// After reset the frame table is cleared one entry a cycle, all MAX_FRAMES (1024) entries,
// with busy high; configuration writes are taken meanwhile.
// An allocate scans the first limit entries for a free run, then marks it,
// where limit is min(frame_count, MAX_FRAMES); a page_count of zero or above limit
// is refused at once. A free searches the managed frames for the address, reads the
// matched entry, then clears one frame a cycle. The table has one read, one write port.
// The result strobe cannot be stalled; busy drops in the cycle it appears.
module contiguous_frame_allocator
  import cfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [10:0] in_page_count,
  input  wire logic [31:0] in_address,
  output logic             out_valid,
  output logic [31:0]      out_start_address,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [31:0]         frame_base_r, frame_base_nxt;
  logic [10:0]         frame_count_r, frame_count_nxt;
  logic [MARK_W-1:0]   want_r, want_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MARK_W-1:0]   run_r, run_nxt;
  logic [MARK_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]    base_r, base_nxt;
  logic [31:0]         pa_r, pa_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    base_calc;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [MARK_W-1:0]   ram_wdata, ram_rdata;

  assign limit = (CNT_W'(frame_count_r) > CNT_W'(MAX_FRAMES)) ?
                 CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_r);
  assign base_calc = rd_idx_r + CNT_W'(1) - CNT_W'(want_r);

  cfa_ram #(
    .WIDTH(MARK_W),
    .DEPTH(MAX_FRAMES)
  ) u_marks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    frame_base_nxt  = frame_base_r;
    frame_count_nxt = frame_count_r;
    want_nxt        = want_r;
    addr_nxt        = addr_r;
    cnt_nxt         = cnt_r;
    run_nxt         = run_r;
    rem_nxt         = rem_r;
    base_nxt        = base_r;
    pa_nxt          = pa_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = cnt_r;
    out_valid_nxt   = 1'b0;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = cnt_r[IDX_W-1:0];
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = cnt_r[IDX_W-1:0];

    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_BASE:  frame_base_nxt = cfg_wdata;
        REG_FRAME_COUNT: frame_count_nxt = cfg_wdata[10:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
        if (cnt_r == CNT_W'(MAX_FRAMES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          want_nxt = in_page_count;
          addr_nxt = in_address;
          cnt_nxt  = '0;
          run_nxt  = '0;
          pa_nxt   = frame_base_r;
          if (in_op == OP_ALLOC) begin
            if (in_page_count == '0 || CNT_W'(in_page_count) > limit) begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = STATUS_NO_MEM;
            end else begin
              state_nxt = ST_ASCAN;
            end
          end else begin
            state_nxt = ST_FSRCH;
          end
        end
      end
      ST_ASCAN: begin
        // Reads run one entry ahead of the run check because the table read is registered.
        if (cnt_r < limit) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (ram_rdata == '0 && run_r + MARK_W'(1) == want_r) begin
            base_nxt  = base_calc[IDX_W-1:0];
            cnt_nxt   = base_calc;
            rem_nxt   = want_r;
            state_nxt = ST_AMARK;
          end else begin
            run_nxt = (ram_rdata == '0) ? run_r + MARK_W'(1) : '0;
            if (rd_idx_r == limit - CNT_W'(1)) begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = STATUS_NO_MEM;
              state_nxt      = ST_IDLE;
            end
          end
        end
      end
      ST_AMARK: begin
        ram_we    = 1'b1;
        ram_wdata = want_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        rem_nxt   = rem_r - MARK_W'(1);
        if (rem_r == MARK_W'(1)) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = frame_base_r + (32'(base_r) << PAGE_SHIFT);
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FSRCH: begin
        // The kernel-virtual alias differs from the physical address only in bit 31.
        if (cnt_r == limit) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STATUS_NOT_FOUND;
          state_nxt      = ST_IDLE;
        end else if (((pa_r ^ addr_r) & ~KSEG_OFFSET) == '0) begin
          ram_re    = 1'b1;
          state_nxt = ST_FREAD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          pa_nxt  = pa_r + 32'(PAGE_BYTES);
        end
      end
      ST_FREAD: begin
        rem_nxt = ram_rdata;
        if (ram_rdata == '0) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_FCLR;
        end
      end
      ST_FCLR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        rem_nxt = rem_r - MARK_W'(1);
        if (rem_r == MARK_W'(1) || cnt_r + CNT_W'(1) == limit) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      frame_base_r  <= '0;
      frame_count_r <= '0;
      cnt_r         <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      out_addr_r    <= '0;
      out_status_r  <= STATUS_OK;
    end else begin
      state_r       <= state_nxt;
      frame_base_r  <= frame_base_nxt;
      frame_count_r <= frame_count_nxt;
      cnt_r         <= cnt_nxt;
      rd_vld_r      <= rd_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      out_addr_r    <= out_addr_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r   <= want_nxt;
    addr_r   <= addr_nxt;
    run_r    <= run_nxt;
    rem_r    <= rem_nxt;
    base_r   <= base_nxt;
    pa_r     <= pa_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_start_address = out_addr_r;
  assign out_status        = out_status_r;

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("table clear did not start after reset");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("frame table written while idle");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction in flight");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_start_address == '0))
    else $error("failed transaction returned a nonzero address");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

import cfa_pkg::*;

typedef struct packed {
  logic [31:0] start_address;
  status_t     status;
} alloc_result_t;

class frame_alloc_scoreboard;
  logic [10:0]   marks [MAX_FRAMES];
  logic [31:0]   frame_base;
  logic [10:0]   frame_count;
  int unsigned   live_bases[$];
  alloc_result_t due_results[$];
  int            errors;

  function new();
    foreach (marks[i]) marks[i] = '0;
    frame_base  = '0;
    frame_count = '0;
    errors      = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] data);
    if (idx == REG_FRAME_BASE) begin
      frame_base = data;
    end else begin
      frame_count = data[10:0];
    end
  endfunction

  function int unsigned managed();
    return (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
  endfunction

  function logic [31:0] frame_addr(int unsigned idx);
    logic [31:0] offset;
    offset = idx * PAGE_BYTES;
    return frame_base + offset;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  // Applies one accepted transaction to the frame table and queues its result.
  function void note_request(logic op, logic [10:0] page_count, logic [31:0] address);
    int unsigned   lim;
    int unsigned   run;
    int unsigned   run_start;
    int unsigned   clear_len;
    bit            hit;
    logic [31:0]   pa;
    logic [31:0]   va;
    alloc_result_t res;
    lim       = managed();
    run       = 0;
    run_start = 0;
    hit       = 1'b0;
    res.start_address = '0;
    if (op == OP_ALLOC) begin
      res.status = STATUS_NO_MEM;
      if (page_count != 0 && page_count <= lim) begin
        for (int unsigned i = 0; i < lim && !hit; i++) begin
          if (marks[i] == 0) begin
            run++;
            if (run == page_count) begin
              run_start = i + 1 - page_count;
              hit       = 1'b1;
            end
          end else begin
            run = 0;
          end
        end
      end
      if (hit) begin
        for (int unsigned j = 0; j < page_count; j++) marks[run_start + j] = page_count;
        res.start_address = frame_addr(run_start);
        res.status        = STATUS_OK;
        live_bases.push_back(run_start);
      end
    end else begin
      res.status = STATUS_NOT_FOUND;
      for (int unsigned i = 0; i < lim && !hit; i++) begin
        pa = frame_addr(i);
        va = pa + KSEG_OFFSET;
        if (pa == address || va == address) begin
          // The clear length comes from the matched frame, even inside a run.
          clear_len = marks[i];
          for (int unsigned j = 0; j < clear_len && i + j < lim; j++) marks[i + j] = '0;
          res.status = STATUS_OK;
          hit        = 1'b1;
        end
      end
    end
    due_results.push_back(res);
  endfunction

  function void check_result(logic [31:0] start_address, logic [1:0] status);
    alloc_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, start_address %h status %0d",
               $time, start_address, status);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (start_address !== want.start_address) begin
      $display("%0t: start_address expected %h, actual %h",
               $time, want.start_address, start_address);
      errors++;
    end
    if (status !== want.status) begin
      $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic        in_op         = OP_ALLOC;
  logic [10:0] in_page_count = '0;
  logic [31:0] in_address    = '0;
  logic        out_valid;
  logic [31:0] out_start_address;
  logic [1:0]  out_status;
  logic        cfg_we        = 1'b0;
  logic        cfg_index     = REG_FRAME_BASE;
  logic [31:0] cfg_wdata     = '0;

  frame_alloc_scoreboard sb = new();
  bit no_idle = 1'b0;

  contiguous_frame_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_page_count     (in_page_count),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_start_address (out_start_address),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #120_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_start_address, out_status);
  end

  function automatic int unsigned idle_gap();
    int unsigned gap;
    gap = 0;
    if (no_idle) return 0;
    if ($urandom_range(0, 99) < 5) return $urandom_range(20, 80);
    while ($urandom_range(0, 99) < 38) gap++;
    return gap;
  endfunction

  function automatic logic [10:0] pick_page_count(int unsigned lim);
    int unsigned roll;
    int unsigned cap;
    roll = $urandom_range(0, 99);
    cap  = (lim < 8) ? ((lim == 0) ? 1 : lim) : lim / 4;
    if (roll < 70) return 11'($urandom_range(1, cap));
    if (roll < 80) return 11'(lim + $urandom_range(0, 1));
    if (roll < 88) return '0;
    return 11'($urandom());
  endfunction

  // About half addresses of live runs, some inside runs or free frames, some past the end, some noise.
  function automatic logic [31:0] pick_free_address(int unsigned lim);
    int unsigned roll;
    int unsigned idx;
    int unsigned k;
    logic [31:0] pa;
    roll = $urandom_range(0, 99);
    if (roll < 50 && sb.live_bases.size() != 0) begin
      k   = $urandom_range(0, sb.live_bases.size() - 1);
      idx = sb.live_bases[k];
      sb.live_bases.delete(k);
    end else if (roll < 75) begin
      idx = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    end else if (roll < 90) begin
      return $urandom();
    end else begin
      idx = lim + $urandom_range(0, 3);
    end
    pa = sb.frame_addr(idx);
    return ($urandom_range(0, 1) == 1) ? pa + KSEG_OFFSET : pa;
  endfunction

  task automatic send(logic op, logic [10:0] page_count, logic [31:0] address);
    int unsigned gap;
    in_op         <= op;
    in_page_count <= page_count;
    in_address    <= address;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(op, page_count, address);
    gap = idle_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_config(logic [31:0] base, logic [10:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_FRAME_COUNT;
    cfg_wdata <= {21'd0, count};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_FRAME_BASE, base);
    sb.set_reg(REG_FRAME_COUNT, {21'd0, count});
  endtask

  initial begin
    int unsigned phase_frames[] = '{16, 8, 32, 64, 1024, 2047, 1, 0, 1000};
    int unsigned phase_items[]  = '{110, 70, 70, 90, 60, 40, 40, 20, 80};
    int unsigned lim;
    int unsigned item_no;
    logic [31:0] base;
    item_no = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Small table whose addresses wrap past the top of the 32-bit space.
    write_config(32'hFFFF_E000, 11'd4);
    send(OP_ALLOC, 11'd0, $urandom());
    send(OP_ALLOC, 11'd5, $urandom());
    send(OP_ALLOC, 11'd1, $urandom());
    send(OP_ALLOC, 11'd2, $urandom());
    send(OP_ALLOC, 11'd1, $urandom());
    send(OP_ALLOC, 11'd1, $urandom());
    send(OP_FREE, 11'd0, sb.frame_addr(1) + KSEG_OFFSET);
    send(OP_FREE, 11'd0, sb.frame_addr(2));
    send(OP_ALLOC, 11'd2, 32'hFFFF_FFFF);
    // Freeing from the middle of a run clears on into the next run.
    send(OP_FREE, 11'h7FF, sb.frame_addr(2));
    send(OP_FREE, 11'd0, 32'h1234_5678);
    send(OP_FREE, 11'd0, sb.frame_addr(0));
    send(OP_ALLOC, 11'd4, $urandom());
    send(OP_FREE, 11'd0, sb.frame_addr(1));
    send(OP_ALLOC, 11'd4, $urandom());
    send(OP_FREE, 11'd0, sb.frame_addr(3));
    send(OP_FREE, 11'd0, sb.frame_addr(0));
    send(OP_ALLOC, 11'h7FF, 32'hFFFF_FFFF);
    send(OP_FREE, 11'h7FF, 32'hFFFF_FFFF);
    drain();

    // Frame count beyond the table depth is clamped to the table.
    write_config(32'h0000_0000, 11'h7FF);
    send(OP_ALLOC, 11'd1024, 32'h0);
    send(OP_FREE, 11'd0, KSEG_OFFSET);
    send(OP_ALLOC, 11'd1025, $urandom());
    send(OP_FREE, 11'd0, sb.frame_addr(MAX_FRAMES));

    for (int p = 0; p < 9; p++) begin
      drain();
      case (p)
        1:       base = 32'hFFFF_C000;
        2:       base = 32'h7FFF_0000;
        3:       base = $urandom();
        4:       base = 32'h0000_0000;
        5:       base = 32'h8000_0000;
        default: base = $urandom() & 32'hFFFF_F000;
      endcase
      write_config(base, 11'(phase_frames[p]));
      lim = sb.managed();
      for (int n = 0; n < phase_items[p]; n++) begin
        no_idle = (item_no >= 150 && item_no < 250);
        item_no++;
        if ($urandom_range(0, 99) < 55) begin
          send(OP_ALLOC, pick_page_count(lim), $urandom());
        end else begin
          send(OP_FREE, 11'($urandom()), pick_free_address(lim));
        end
      end
    end
    drain();

    // Any stray strobe after the last result shows up as unexpected.
    repeat (2 * MAX_FRAMES + 64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/cfa_pkg.sv
src/cfa_ram.sv
src/contiguous_frame_allocator.sv
tb/sv/testbench.sv
